### hw/rtl/sapq_pkg.sv
package sapq_pkg;

    localparam int KEY_W            = 32;
    localparam int ACT_W            = 2;
    localparam int STAT_W           = 2;
    localparam int DEFAULT_CAPACITY = 64;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT,
        ACT_DELETE,
        ACT_CHANGE,
        ACT_GET_MIN
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_NOT_FOUND,
        ST_FULL
    } status_t;

    // memory read address source
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1
    } rd_sel_t;

    // index register update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef struct packed {
        logic    load;         // capture an input transaction
        idx_op_t idx_op;
        rd_sel_t rd_sel;
        logic    wr_ins;       // mem[idx] <= key being placed
        logic    wr_data;      // mem[idx] <= last read data
        logic    cnt_inc;
        logic    cnt_dec;
        logic    use_new_key;  // key being placed <= replacement key
        logic    set_status;
        status_t status;
        logic    publish;      // load output register
    } sapq_cmd_t;

    typedef struct packed {
        action_t action;
        logic    empty;
        logic    full;
        logic    idx_zero;
        logic    idx_at_count;
        logic    idx_last;     // idx + 1 == count
        logic    ins_lt;       // placed key < read data
        logic    key_eq;       // search key == read data
        logic    key_lt;       // search key < read data
    } sapq_stat_t;

endpackage

### hw/rtl/sapq_datapath.sv
module sapq_datapath #(
    parameter int CAPACITY = sapq_pkg::DEFAULT_CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sapq_pkg::sapq_cmd_t              cmd,
    output sapq_pkg::sapq_stat_t             stat,
    input  logic [sapq_pkg::ACT_W-1:0]       in_action,
    input  logic signed [sapq_pkg::KEY_W-1:0] in_key,
    input  logic signed [sapq_pkg::KEY_W-1:0] in_new_key,
    output logic [sapq_pkg::STAT_W-1:0]      out_status,
    output logic signed [sapq_pkg::KEY_W-1:0] out_min,
    output logic [CW-1:0]                    out_count
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic signed [sapq_pkg::KEY_W-1:0] mem [CAPACITY];

    sapq_pkg::action_t                 action_reg;
    sapq_pkg::status_t                 status_reg;
    logic signed [sapq_pkg::KEY_W-1:0] key_reg;
    logic signed [sapq_pkg::KEY_W-1:0] new_key_reg;
    logic signed [sapq_pkg::KEY_W-1:0] ins_key_reg;
    logic signed [sapq_pkg::KEY_W-1:0] rdata_reg;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     idx_reg;

    logic [CW-1:0]                     idx_m1;
    logic [CW-1:0]                     idx_p1;
    logic [AW-1:0]                     rd_addr;
    logic [AW-1:0]                     wr_addr;
    logic                              wr_en;
    logic signed [sapq_pkg::KEY_W-1:0] wr_val;

    assign idx_m1  = idx_reg - CW'(1);
    assign idx_p1  = idx_reg + CW'(1);
    assign wr_addr = idx_reg[AW-1:0];
    assign wr_en   = cmd.wr_ins | cmd.wr_data;
    assign wr_val  = cmd.wr_ins ? ins_key_reg : rdata_reg;

    always_comb begin
        unique case (cmd.rd_sel)
            sapq_pkg::RD_ZERO:   rd_addr = '0;
            sapq_pkg::RD_IDX:    rd_addr = idx_reg[AW-1:0];
            sapq_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
            sapq_pkg::RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
            default:             rd_addr = '0;
        endcase
    end

    // key store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_val;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.cnt_inc) begin
            count_reg <= count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg  <= sapq_pkg::action_t'(in_action);
            key_reg     <= in_key;
            new_key_reg <= in_new_key;
            ins_key_reg <= in_key;
            status_reg  <= sapq_pkg::ST_OK;
        end else begin
            if (cmd.use_new_key) begin
                ins_key_reg <= new_key_reg;
            end
            if (cmd.set_status) begin
                status_reg <= cmd.status;
            end
        end

        unique case (cmd.idx_op)
            sapq_pkg::IDX_HOLD:  idx_reg <= idx_reg;
            sapq_pkg::IDX_ZERO:  idx_reg <= '0;
            sapq_pkg::IDX_COUNT: idx_reg <= count_reg;
            sapq_pkg::IDX_INC:   idx_reg <= idx_p1;
            sapq_pkg::IDX_DEC:   idx_reg <= idx_m1;
            default:             idx_reg <= idx_reg;
        endcase

        if (cmd.publish) begin
            out_status <= status_reg;
            out_min    <= (count_reg == '0) ? '1 : rdata_reg;
            out_count  <= count_reg;
        end
    end

    always_comb begin
        stat.action       = action_reg;
        stat.empty        = (count_reg == '0);
        stat.full         = (count_reg == CAP_C);
        stat.idx_zero     = (idx_reg == '0);
        stat.idx_at_count = (idx_reg == count_reg);
        stat.idx_last     = (idx_p1 == count_reg);
        stat.ins_lt       = (ins_key_reg < rdata_reg);
        stat.key_eq       = (key_reg == rdata_reg);
        stat.key_lt       = (key_reg < rdata_reg);
    end

endmodule

### hw/rtl/sapq_ctrl.sv
module sapq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  sapq_pkg::sapq_stat_t stat,
    output sapq_pkg::sapq_cmd_t  cmd
);

    typedef enum logic [3:0] {
        IDLE,
        DISPATCH,
        INS_CHECK,
        INS_CMP,
        DEL_CHECK,
        DEL_CMP,
        SHF_CHECK,
        SHF_MOVE,
        MIN_RD,
        PUB
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = DISPATCH;
                end
            end
            DISPATCH: begin
                unique case (stat.action)
                    sapq_pkg::ACT_INSERT: begin
                        if (stat.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = sapq_pkg::ST_FULL;
                            state_next     = MIN_RD;
                        end else begin
                            cmd.idx_op = sapq_pkg::IDX_COUNT;
                            state_next = INS_CHECK;
                        end
                    end
                    sapq_pkg::ACT_DELETE, sapq_pkg::ACT_CHANGE: begin
                        if (stat.empty) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = sapq_pkg::ST_EMPTY;
                            state_next     = MIN_RD;
                        end else begin
                            cmd.idx_op = sapq_pkg::IDX_ZERO;
                            state_next = DEL_CHECK;
                        end
                    end
                    default: begin
                        if (stat.empty) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = sapq_pkg::ST_EMPTY;
                        end
                        state_next = MIN_RD;
                    end
                endcase
            end
            // walk down from the top, moving larger keys up one slot
            INS_CHECK: begin
                if (stat.idx_zero) begin
                    cmd.wr_ins  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = MIN_RD;
                end else begin
                    cmd.rd_sel = sapq_pkg::RD_IDX_M1;
                    state_next = INS_CMP;
                end
            end
            INS_CMP: begin
                if (stat.ins_lt) begin
                    cmd.wr_data = 1'b1;
                    cmd.idx_op  = sapq_pkg::IDX_DEC;
                    state_next  = INS_CHECK;
                end else begin
                    cmd.wr_ins  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = MIN_RD;
                end
            end
            // search upward for the first equal key
            DEL_CHECK: begin
                if (stat.idx_at_count) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sapq_pkg::ST_NOT_FOUND;
                    state_next     = MIN_RD;
                end else begin
                    cmd.rd_sel = sapq_pkg::RD_IDX;
                    state_next = DEL_CMP;
                end
            end
            DEL_CMP: begin
                priority if (stat.key_eq) begin
                    state_next = SHF_CHECK;
                end else if (stat.key_lt) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sapq_pkg::ST_NOT_FOUND;
                    state_next     = MIN_RD;
                end else begin
                    cmd.idx_op = sapq_pkg::IDX_INC;
                    state_next = DEL_CHECK;
                end
            end
            // close the gap; on the last slot idx equals the new count
            SHF_CHECK: begin
                if (stat.idx_last) begin
                    cmd.cnt_dec = 1'b1;
                    if (stat.action == sapq_pkg::ACT_CHANGE) begin
                        cmd.use_new_key = 1'b1;
                        state_next      = INS_CHECK;
                    end else begin
                        state_next = MIN_RD;
                    end
                end else begin
                    cmd.rd_sel = sapq_pkg::RD_IDX_P1;
                    state_next = SHF_MOVE;
                end
            end
            SHF_MOVE: begin
                cmd.wr_data = 1'b1;
                cmd.idx_op  = sapq_pkg::IDX_INC;
                state_next  = SHF_CHECK;
            end
            MIN_RD: begin
                cmd.rd_sel = sapq_pkg::RD_ZERO;
                state_next = PUB;
            end
            PUB: begin
                cmd.rd_sel = sapq_pkg::RD_ZERO;
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.publish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/sorted_array_priority_queue_core.sv
// Each transaction is taken, dispatched on its action, then walks the key store one key
// compared or moved at a time; every path ends by reading slot 0 and publishing the result.
// The slowest transaction is a change of the largest key into the smallest.
// Flow: one transaction in flight; the next is taken while a result waits.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
module sorted_array_priority_queue_core #(
    parameter int CAPACITY = sapq_pkg::DEFAULT_CAPACITY,
    localparam int CW  = $clog2(CAPACITY + 1),
    localparam int ODW = ((sapq_pkg::KEY_W + CW + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input transactions
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [2*sapq_pkg::KEY_W-1:0] s_axis_tdata,  // key, new_key
    input  logic [sapq_pkg::ACT_W-1:0]   s_axis_tuser,  // action
    // result transactions
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [ODW-1:0]               m_axis_tdata,  // min_key, entry_count, zero pad
    output logic [sapq_pkg::STAT_W-1:0]  m_axis_tuser   // status
);

    sapq_pkg::sapq_cmd_t               cmd;
    sapq_pkg::sapq_stat_t              stat;
    logic [sapq_pkg::STAT_W-1:0]       out_status;
    logic signed [sapq_pkg::KEY_W-1:0] out_min;
    logic [CW-1:0]                     out_count;

    // Controller sequences the search/shift walks; datapath owns the store.
    sapq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sapq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_axis_tuser),
        .in_key     (s_axis_tdata[sapq_pkg::KEY_W-1:0]),
        .in_new_key (s_axis_tdata[2*sapq_pkg::KEY_W-1:sapq_pkg::KEY_W]),
        .out_status (out_status),
        .out_min    (out_min),
        .out_count  (out_count)
    );

    assign m_axis_tdata = ODW'({out_count, out_min});
    assign m_axis_tuser = out_status;

    // count never passes the store size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (out_count <= CW'(CAPACITY)))
        else $error("entry_count above capacity");

    // an empty report comes only with an empty store
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (out_status == sapq_pkg::ST_EMPTY)) |-> (out_count == '0))
        else $error("empty status with nonzero count");

    // a dropped insert comes only with a full store
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (out_status == sapq_pkg::ST_FULL)) |-> (out_count == CW'(CAPACITY)))
        else $error("full status below capacity");

    // empty store reports minimum of -1
    a_empty_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (out_count == '0)) |-> (out_min == -32'sd1))
        else $error("empty store with minimum other than -1");

endmodule

### bench/sapq_queue_checker.sv
module sapq_queue_checker import sapq_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    localparam int CW  = $clog2(CAPACITY + 1),
    localparam int ODW = ((KEY_W + CW + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [2*KEY_W-1:0] s_axis_tdata,   // key, new_key
    input  logic [ACT_W-1:0]   s_axis_tuser,   // action
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [ODW-1:0]     m_axis_tdata,   // min_key, entry_count, zero pad
    input  logic [STAT_W-1:0]  m_axis_tuser,   // status
    output int                 fail_count,
    output int                 results_owed
);

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] min_key;
        logic [CW-1:0]    count;
    } outcome_t;

    // ascending copy of the stored keys
    logic signed [KEY_W-1:0] shelf[$];
    outcome_t                owed_outcomes[$];
    int                      bad = 0;

    // new key goes after any equal keys
    function automatic void place_key(logic signed [KEY_W-1:0] k);
        int pos;
        pos = 0;
        while (pos < shelf.size() && !(k < shelf[pos]))
            pos++;
        shelf.insert(pos, k);
    endfunction

    function automatic outcome_t run_action(action_t act, logic signed [KEY_W-1:0] k,
                                            logic signed [KEY_W-1:0] nk);
        outcome_t o;
        int       hit;
        o.status = ST_OK;
        case (act)
            ACT_INSERT: begin
                if (shelf.size() >= CAPACITY)
                    o.status = ST_FULL;
                else
                    place_key(k);
            end
            ACT_DELETE, ACT_CHANGE: begin
                if (shelf.size() == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    hit = -1;
                    for (int i = 0; i < shelf.size(); i++) begin
                        if (shelf[i] == k) begin
                            hit = i;
                            break;
                        end
                    end
                    if (hit < 0) begin
                        o.status = ST_NOT_FOUND;
                    end else begin
                        shelf.delete(hit);
                        if (act == ACT_CHANGE)
                            place_key(nk);
                    end
                end
            end
            default: begin
                if (shelf.size() == 0)
                    o.status = ST_EMPTY;
            end
        endcase
        o.min_key = (shelf.size() == 0) ? '1 : shelf[0];
        o.count   = CW'(shelf.size());
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [KEY_W-1:0] got,
                                   logic [KEY_W-1:0] want);
        $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
        bad++;
    endtask

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            shelf.delete();
            owed_outcomes.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status  = status_t'(m_axis_tuser);
                got.min_key = m_axis_tdata[KEY_W-1:0];
                got.count   = m_axis_tdata[KEY_W +: CW];
                if (owed_outcomes.size() == 0) begin
                    report_mismatch("unrequested result status", KEY_W'(got.status), '0);
                end else begin
                    want = owed_outcomes.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", KEY_W'(got.status), KEY_W'(want.status));
                    if (got.min_key != want.min_key)
                        report_mismatch("min_key", got.min_key, want.min_key);
                    if (got.count != want.count)
                        report_mismatch("entry_count", KEY_W'(got.count), KEY_W'(want.count));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                owed_outcomes.push_back(run_action(action_t'(s_axis_tuser),
                                                   s_axis_tdata[KEY_W-1:0],
                                                   s_axis_tdata[2*KEY_W-1:KEY_W]));
        end
        results_owed <= owed_outcomes.size();
        fail_count   <= bad;
    end

endmodule

### bench/sorted_array_priority_queue_core_tb.sv
module sorted_array_priority_queue_core_tb;
    import sapq_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int CW           = $clog2(CAPACITY + 1);
    localparam int ODW          = ((KEY_W + CW + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 850;
    // room for the slowest item plus the idling of sender and receiver
    localparam int TAIL_CYCLES  = 4 * CAPACITY + 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int POOL_SIZE    = 12;

    localparam logic [KEY_W-1:0] KEY_MOST_NEG  = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MOST_POS  = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_MINUS_ONE = 32'hFFFF_FFFF;

    // operation mix of one random phase
    typedef enum {PH_FILL, PH_DRAIN, PH_MIX} mix_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [2*KEY_W-1:0] s_axis_tdata  = '0;   // key, new_key
    logic [ACT_W-1:0]   s_axis_tuser  = '0;   // action
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [ODW-1:0]     m_axis_tdata;         // min_key, entry_count, zero pad
    logic [STAT_W-1:0]  m_axis_tuser;         // status

    int          fail_count;
    int          results_owed;
    int unsigned cycles    = 0;
    bit          tx_steady = 1'b0;   // sender runs back to back
    bit          rx_steady = 1'b0;   // receiver never stalls
    int          rx_hold   = 0;

    // keys that recur, so deletes and changes find something
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    sorted_array_priority_queue_core #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    sapq_queue_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: after each transaction draw a random hold and keep tready low while it runs.
    // Now and then switch into or out of a no-stall stretch.
    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            n = rx_steady ? 0 : $urandom_range(0, 5);
            rx_hold       <= n;
            m_axis_tready <= (n == 0);
        end else if (rx_hold != 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= (rx_hold == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // One input transaction. Valid stays high into the next item when there is
    // no gap, so it is never dropped and raised in the same step.
    task automatic send_op(action_t act, logic [KEY_W-1:0] k, logic [KEY_W-1:0] nk);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nk, k};
        s_axis_tuser  <= act;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // stop sending until every outstanding result has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    // Pool keys are mostly small values near zero (many duplicates), with the
    // extremes and full-range patterns mixed in.
    function automatic logic [KEY_W-1:0] fresh_pool_key();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return KEY_MOST_NEG;
                    1:       return KEY_MOST_POS;
                    2:       return KEY_MINUS_ONE;
                    default: return '0;
                endcase
            end
            1:       return $urandom();
            default: return $urandom_range(0, 100) - 50;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    initial begin
        mix_t    mode;
        int      phase_len;
        int      sent;
        int      r;
        action_t act;

        foreach (key_pool[i])
            key_pool[i] = fresh_pool_key();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed part ---
        // everything on an empty queue reports empty
        send_op(ACT_GET_MIN, 32'd0, 32'd0);
        send_op(ACT_DELETE, 32'd5, 32'd0);
        send_op(ACT_CHANGE, 32'd5, 32'd6);
        // a lone -1 key: min_key equals the empty marker, count tells them apart
        send_op(ACT_INSERT, KEY_MINUS_ONE, 32'd0);
        send_op(ACT_GET_MIN, 32'd0, 32'd0);
        send_op(ACT_DELETE, KEY_MINUS_ONE, 32'd0);
        // extremes in mixed order, plus a duplicate
        send_op(ACT_INSERT, KEY_MOST_POS, 32'd0);
        send_op(ACT_INSERT, KEY_MOST_NEG, 32'd0);
        send_op(ACT_INSERT, KEY_MINUS_ONE, 32'd0);
        send_op(ACT_INSERT, 32'd0, 32'd0);
        send_op(ACT_INSERT, KEY_MINUS_ONE, 32'd0);
        send_op(ACT_GET_MIN, 32'd0, 32'd0);
        // absent keys inside the stored range
        send_op(ACT_DELETE, 32'd12345, 32'd0);
        send_op(ACT_CHANGE, 32'hFFFF_FFFE, KEY_MOST_NEG);
        // change moves keys across the range, and onto itself
        send_op(ACT_CHANGE, KEY_MINUS_ONE, KEY_MOST_POS);
        send_op(ACT_CHANGE, KEY_MOST_NEG, KEY_MOST_NEG);
        send_op(ACT_CHANGE, KEY_MOST_POS, 32'h5555_5555);
        send_op(ACT_CHANGE, 32'h5555_5555, 32'hAAAA_AAAA);
        // drain everything
        send_op(ACT_DELETE, KEY_MOST_NEG, 32'd0);
        send_op(ACT_DELETE, 32'hAAAA_AAAA, 32'd0);
        send_op(ACT_DELETE, KEY_MINUS_ONE, 32'd0);
        send_op(ACT_DELETE, 32'd0, 32'd0);
        send_op(ACT_DELETE, KEY_MOST_POS, 32'd0);
        send_op(ACT_GET_MIN, 32'd0, 32'd0);
        wait_idle();

        // --- random part ---
        // The first phase fills the queue, so inserts into a full store come early.
        sent      = 0;
        mode      = PH_FILL;
        phase_len = 100;
        while (sent < RANDOM_ITEMS) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                case (mode)
                    PH_FILL:
                        act = r < 80 ? ACT_INSERT : r < 88 ? ACT_CHANGE :
                              r < 94 ? ACT_DELETE : ACT_GET_MIN;
                    PH_DRAIN:
                        act = r < 15 ? ACT_INSERT : r < 70 ? ACT_DELETE :
                              r < 85 ? ACT_CHANGE : ACT_GET_MIN;
                    default:
                        act = r < 35 ? ACT_INSERT : r < 65 ? ACT_DELETE :
                              r < 85 ? ACT_CHANGE : ACT_GET_MIN;
                endcase
                send_op(act, pick_key(), pick_key());
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                wait_idle();
            // swap a few pool entries; most stored keys stay findable
            repeat (3) key_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_pool_key();
            mode      = mix_t'($urandom_range(0, 2));
            phase_len = $urandom_range(40, 120);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
